// ===== sv/ffba_pkg.sv =====
// ----------------------------------------------------------------------------
// First-fit block allocator package
// Shared constants, payload structs and the controller state type.
// ----------------------------------------------------------------------------
`default_nettype none
package ffba_pkg;

    localparam int POOL_BYTES    = 4096;
    localparam int TABLE_ENTRIES = 512;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int LINK_W        = IDX_W + 1;
    localparam int OFS_W         = 12;
    localparam int LEN_W         = 13;
    localparam int STEP_W        = IDX_W + 1;

    // List links carry one extra bit so that every table index stays distinct
    // from the end-of-list code.
    localparam logic [LINK_W-1:0] NO_ENTRY = '1;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_SIZE  = 3'd1;
    localparam logic [2:0] ST_NO_FIT    = 3'd2;
    localparam logic [2:0] ST_NO_SPARE  = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND = 3'd4;

    typedef struct packed {
        logic             command;
        logic [LEN_W-1:0] request_size;
        logic [OFS_W-1:0] free_offset;
    } req_t;

    typedef struct packed {
        logic [2:0]       status;
        logic [OFS_W-1:0] block_offset;
    } rsp_t;

    typedef struct packed {
        logic [OFS_W-1:0]  start;
        logic [LEN_W-1:0]  length;
        logic              is_free;
        logic [LINK_W-1:0] following;
        logic [LINK_W-1:0] preceding;
    } entry_t;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_WALK_RD,
        S_WALK_CHK,
        S_SPARE_RD,
        S_SPARE_CHK,
        S_SPLIT_NX_RD,
        S_SPLIT_NX_WR,
        S_FREE_NX_RD,
        S_FREE_NX_CHK,
        S_FREE_AF_RD,
        S_FREE_AF_WR,
        S_FREE_PV_RD,
        S_FREE_PV_CHK,
        S_FREE_PA_RD,
        S_FREE_PA_WR,
        S_DONE
    } state_t;

endpackage
`default_nettype wire

// ===== sv/ffba_table.sv =====
// ----------------------------------------------------------------------------
// Descriptor table
// Single-port synchronous memory of block descriptors, registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module ffba_table (
    input  wire logic                      clk,
    input  wire logic                      we,
    input  wire logic [ffba_pkg::IDX_W-1:0] addr,
    input  wire ffba_pkg::entry_t          wdata,
    output ffba_pkg::entry_t               rdata
);

    ffba_pkg::entry_t mem [ffba_pkg::TABLE_ENTRIES];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule
`default_nettype wire

// ===== sv/first_fit_block_allocator.sv =====
// ----------------------------------------------------------------------------
// First-fit block allocator
// Address-ordered block list with first-fit allocation and coalescing free.
// ----------------------------------------------------------------------------
// The block keeps a table of TABLE_ENTRIES block descriptors in one
// single-port memory and serves one request at a time. After reset a clearing
// pass writes every table entry, during which no request is taken. An
// allocate request walks the block list from entry 0; when the chosen block
// must be split, a scan for the lowest spare entry follows, and then the
// split entries are written back. A free request walks the list the same way
// and then merges neighbours. The single memory port is shared by every read
// and write. The result sits in an output register, and the next request is
// taken once it has left.
`default_nettype none
module first_fit_block_allocator (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_stall,
    input  wire ffba_pkg::req_t in_data,
    output logic                out_valid,
    input  wire logic           out_stall,
    output ffba_pkg::rsp_t      out_data
);

    localparam int IW = ffba_pkg::IDX_W;
    localparam int KW = ffba_pkg::LINK_W;
    localparam int SW = ffba_pkg::STEP_W;
    localparam int LW = ffba_pkg::LEN_W;
    localparam int OW = ffba_pkg::OFS_W;

    ffba_pkg::state_t state_reg, state_next;

    // Request and working registers.
    ffba_pkg::req_t   req_reg, req_next;
    logic [KW-1:0]    cur_reg, cur_next;     // list entry under examination
    logic [SW-1:0]    steps_reg, steps_next; // bounded list-walk counter
    logic [IW-1:0]    idx_reg, idx_next;     // spare-scan index, or work index
    ffba_pkg::entry_t ce_reg, ce_next;       // copy of the current entry
    logic [KW-1:0]    aux_reg, aux_next;     // spare or neighbour index
    ffba_pkg::rsp_t   rsp_reg, rsp_next;
    logic             out_valid_reg, out_valid_next;

    // Memory port.
    logic             mem_we;
    logic [IW-1:0]    mem_addr;
    ffba_pkg::entry_t mem_wdata, mem_rdata;

    ffba_table u_table (
        .clk  (clk),
        .we   (mem_we),
        .addr (mem_addr),
        .wdata(mem_wdata),
        .rdata(mem_rdata)
    );

    ffba_pkg::entry_t blank;
    assign blank = '{start: '0, length: '0, is_free: 1'b0,
                     following: ffba_pkg::NO_ENTRY, preceding: ffba_pkg::NO_ENTRY};

    // A link names an entry only if it is below the table depth.
    function automatic logic names(input logic [KW-1:0] i);
        names = (i < KW'(ffba_pkg::TABLE_ENTRIES));
    endfunction

    assign in_stall  = (state_reg != ffba_pkg::S_IDLE) || out_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = rsp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ffba_pkg::S_CLEAR;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg   <= req_next;
        cur_reg   <= cur_next;
        steps_reg <= steps_next;
        ce_reg    <= ce_next;
        aux_reg   <= aux_next;
        rsp_reg   <= rsp_next;
    end

    always_comb
    begin
        logic [LW-1:0] sum;
        state_next     = state_reg;
        req_next       = req_reg;
        cur_next       = cur_reg;
        steps_next     = steps_reg;
        idx_next       = idx_reg;
        ce_next        = ce_reg;
        aux_next       = aux_reg;
        rsp_next       = rsp_reg;
        out_valid_next = out_valid_reg;
        mem_we         = 1'b0;
        mem_addr       = IW'(cur_reg);
        mem_wdata      = ce_reg;
        sum            = '0;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ffba_pkg::S_CLEAR:
            begin
                // Entry 0 holds the whole pool; every other entry is blank.
                mem_we    = 1'b1;
                mem_addr  = idx_reg;
                mem_wdata = blank;
                if (idx_reg == '0)
                begin
                    mem_wdata.length  = LW'(ffba_pkg::POOL_BYTES);
                    mem_wdata.is_free = 1'b1;
                end
                idx_next = idx_reg + 1'b1;
                if (idx_reg == IW'(ffba_pkg::TABLE_ENTRIES - 1))
                begin
                    state_next = ffba_pkg::S_IDLE;
                end
            end

            ffba_pkg::S_IDLE:
            begin
                if (in_valid && !in_stall)
                begin
                    req_next   = in_data;
                    cur_next   = '0;
                    steps_next = '0;
                    rsp_next   = '{status: ffba_pkg::ST_OK, block_offset: '0};
                    if (in_data.command == ffba_pkg::CMD_ALLOC &&
                        (in_data.request_size == '0 || in_data.request_size[2:0] != 3'd0))
                    begin
                        rsp_next.status = ffba_pkg::ST_BAD_SIZE;
                        state_next      = ffba_pkg::S_DONE;
                    end
                    else
                    begin
                        state_next = ffba_pkg::S_WALK_RD;
                    end
                end
            end

            ffba_pkg::S_WALK_RD:
            begin
                if (steps_reg == SW'(ffba_pkg::TABLE_ENTRIES) || !names(cur_reg))
                begin
                    rsp_next.status = (req_reg.command == ffba_pkg::CMD_ALLOC) ?
                                      ffba_pkg::ST_NO_FIT : ffba_pkg::ST_NOT_FOUND;
                    state_next = ffba_pkg::S_DONE;
                end
                else
                begin
                    mem_addr   = IW'(cur_reg);
                    state_next = ffba_pkg::S_WALK_CHK;
                end
            end

            ffba_pkg::S_WALK_CHK:
            begin
                ce_next    = mem_rdata;
                steps_next = steps_reg + 1'b1;
                cur_next   = mem_rdata.following;
                state_next = ffba_pkg::S_WALK_RD;
                if (req_reg.command == ffba_pkg::CMD_ALLOC)
                begin
                    if (mem_rdata.is_free && mem_rdata.length >= req_reg.request_size)
                    begin
                        cur_next = cur_reg;
                        rsp_next.block_offset = mem_rdata.start;
                        if (mem_rdata.length > req_reg.request_size)
                        begin
                            idx_next   = IW'(1);
                            state_next = ffba_pkg::S_SPARE_RD;
                        end
                        else
                        begin
                            mem_we            = 1'b1;
                            mem_addr          = IW'(cur_reg);
                            mem_wdata         = mem_rdata;
                            mem_wdata.is_free = 1'b0;
                            state_next        = ffba_pkg::S_DONE;
                        end
                    end
                end
                else if (mem_rdata.start == req_reg.free_offset)
                begin
                    cur_next        = cur_reg;
                    ce_next.is_free = 1'b1;
                    state_next      = ffba_pkg::S_FREE_NX_RD;
                end
            end

            // Lowest spare entry above 0: start and length both zero.
            ffba_pkg::S_SPARE_RD:
            begin
                if (idx_reg == '0)
                begin
                    rsp_next = '{status: ffba_pkg::ST_NO_SPARE, block_offset: '0};
                    state_next = ffba_pkg::S_DONE;
                end
                else
                begin
                    mem_addr   = idx_reg;
                    state_next = ffba_pkg::S_SPARE_CHK;
                end
            end

            ffba_pkg::S_SPARE_CHK:
            begin
                if (mem_rdata.length == '0 && mem_rdata.start == '0)
                begin
                    aux_next  = KW'(idx_reg);
                    // Write the remainder into the spare entry.
                    mem_we    = 1'b1;
                    mem_addr  = idx_reg;
                    mem_wdata = '{start: ce_reg.start + OW'(req_reg.request_size),
                                  length: ce_reg.length - req_reg.request_size,
                                  is_free: 1'b1, following: ce_reg.following,
                                  preceding: cur_reg};
                    state_next = ffba_pkg::S_SPLIT_NX_RD;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ffba_pkg::S_SPARE_RD;
                end
            end

            ffba_pkg::S_SPLIT_NX_RD:
            begin
                // Shrink and take the chosen block.
                mem_we    = 1'b1;
                mem_addr  = IW'(cur_reg);
                mem_wdata = ce_reg;
                mem_wdata.following = aux_reg;
                mem_wdata.length    = req_reg.request_size;
                mem_wdata.is_free   = 1'b0;
                state_next = names(ce_reg.following) ? ffba_pkg::S_SPLIT_NX_WR
                                                     : ffba_pkg::S_DONE;
                idx_next   = IW'(ce_reg.following);
            end

            ffba_pkg::S_SPLIT_NX_WR:
            begin
                // Read of the successor; patch its back link next cycle.
                mem_addr   = idx_reg;
                state_next = ffba_pkg::S_FREE_AF_WR;
                aux_next   = aux_reg;
            end

            ffba_pkg::S_FREE_NX_RD:
            begin
                if (names(ce_reg.following))
                begin
                    mem_addr   = IW'(ce_reg.following);
                    state_next = ffba_pkg::S_FREE_NX_CHK;
                end
                else
                begin
                    state_next = ffba_pkg::S_FREE_PV_RD;
                end
            end

            ffba_pkg::S_FREE_NX_CHK:
            begin
                if (mem_rdata.is_free)
                begin
                    // Absorb the next block and wipe its entry.
                    sum = ce_reg.length + mem_rdata.length;
                    ce_next.length    = sum;
                    ce_next.following = mem_rdata.following;
                    mem_we    = 1'b1;
                    mem_addr  = IW'(ce_reg.following);
                    mem_wdata = blank;
                    idx_next  = IW'(mem_rdata.following);
                    aux_next  = cur_reg;
                    state_next = names(mem_rdata.following) ? ffba_pkg::S_FREE_AF_RD
                                                            : ffba_pkg::S_FREE_PV_RD;
                end
                else
                begin
                    state_next = ffba_pkg::S_FREE_PV_RD;
                end
            end

            ffba_pkg::S_FREE_AF_RD:
            begin
                mem_addr   = idx_reg;
                state_next = ffba_pkg::S_FREE_AF_WR;
            end

            // Set entry idx_reg's back link to aux_reg.
            ffba_pkg::S_FREE_AF_WR:
            begin
                mem_we    = 1'b1;
                mem_addr  = idx_reg;
                mem_wdata = mem_rdata;
                mem_wdata.preceding = aux_reg;
                if (req_reg.command == ffba_pkg::CMD_ALLOC)
                begin
                    state_next = ffba_pkg::S_DONE;
                end
                else if (aux_reg == cur_reg)
                begin
                    state_next = ffba_pkg::S_FREE_PV_RD;
                end
                else
                begin
                    state_next = ffba_pkg::S_DONE;
                end
            end

            ffba_pkg::S_FREE_PV_RD:
            begin
                // Write back the current entry, then look at its predecessor.
                mem_we    = 1'b1;
                mem_addr  = IW'(cur_reg);
                mem_wdata = ce_reg;
                state_next = names(ce_reg.preceding) ? ffba_pkg::S_FREE_PV_CHK
                                                     : ffba_pkg::S_DONE;
            end

            ffba_pkg::S_FREE_PV_CHK:
            begin
                mem_addr   = IW'(ce_reg.preceding);
                state_next = ffba_pkg::S_FREE_PA_RD;
            end

            ffba_pkg::S_FREE_PA_RD:
            begin
                if (mem_rdata.is_free)
                begin
                    sum = mem_rdata.length + ce_reg.length;
                    mem_we    = 1'b1;
                    mem_addr  = IW'(ce_reg.preceding);
                    mem_wdata = mem_rdata;
                    mem_wdata.length    = sum;
                    mem_wdata.following = ce_reg.following;
                    state_next = ffba_pkg::S_FREE_PA_WR;
                end
                else
                begin
                    state_next = ffba_pkg::S_DONE;
                end
            end

            ffba_pkg::S_FREE_PA_WR:
            begin
                mem_we    = 1'b1;
                mem_addr  = IW'(cur_reg);
                mem_wdata = blank;
                idx_next  = IW'(ce_reg.following);
                aux_next  = ce_reg.preceding;
                state_next = names(ce_reg.following) ? ffba_pkg::S_FREE_AF_RD
                                                     : ffba_pkg::S_DONE;
            end

            ffba_pkg::S_DONE:
            begin
                if (!out_valid_reg)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ffba_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = ffba_pkg::S_IDLE;
            end
        endcase
    end

    // A request is only taken while the controller is idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |-> state_reg == ffba_pkg::S_IDLE)
        else $error("request taken while busy");

    // A result never appears without a finished request.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg) == ffba_pkg::S_DONE)
        else $error("result without request");

    // Only a successful allocate reports a nonzero offset.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.block_offset != '0) |-> out_data.status == ffba_pkg::ST_OK)
        else $error("offset on failure");

    // The clearing pass ends before any request is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ffba_pkg::S_CLEAR |-> in_stall)
        else $error("request during clear");

endmodule
`default_nettype wire
